/* hw/rtl/sasb_pkg.sv */
// shared types and constants for the saturating additive sprite blitter
// used by sasb_ctrl, sasb_dp and saturating_additive_sprite_blit_top; no dependencies

package sasb_pkg;

   // signed coordinate width: 10-bit origin plus 8-bit offset
   localparam int COORD_W = 11;

   localparam logic [7:0] PIX_MAX = 8'd255;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_START = 2'd1,
      MODE_PIXEL = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_ADDR,
      ST_PIX_FETCH,
      ST_PIX_WRITE,
      ST_RD_ADDR,
      ST_RD_FETCH,
      ST_RD_RESP
   } state_type;

   typedef struct packed {
      logic clear_start;
      logic clear_step;
      logic start_sprite;
      logic advance;
      logic latch;
      logic calc_addr;
      logic mem_read;
      logic mem_write;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic sprite_active;
      logic hit;
      logic clear_last;
      logic rsp_free;
   } status_type;

endpackage

/* hw/rtl/sasb_ctrl.sv */
// controller state machine of the sprite blitter
// depends on sasb_pkg; drives commands into sasb_dp

module sasb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_mode,
   input  sasb_pkg::status_type status,
   output logic                 req_stall,
   output sasb_pkg::cmd_type    cmd
);

   sasb_pkg::state_type state_ff;
   sasb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sasb_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != sasb_pkg::ST_IDLE);
      unique case (state_ff)
         sasb_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = sasb_pkg::ST_IDLE;
            end
         end
         sasb_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (sasb_pkg::mode_type'(req_mode))
                  sasb_pkg::MODE_CLEAR: begin
                     cmd.clear_start = 1'b1;
                     state_in        = sasb_pkg::ST_CLEAR;
                  end
                  sasb_pkg::MODE_START: begin
                     cmd.start_sprite = 1'b1;
                  end
                  sasb_pkg::MODE_PIXEL: begin
                     if (status.sprite_active) begin
                        cmd.advance = 1'b1;
                        cmd.latch   = 1'b1;
                        // off-frame pixels only move the sprite position
                        if (status.hit) begin
                           state_in = sasb_pkg::ST_PIX_ADDR;
                        end
                     end
                  end
                  sasb_pkg::MODE_READ: begin
                     cmd.latch = 1'b1;
                     state_in  = sasb_pkg::ST_RD_ADDR;
                  end
                  default: begin
                     state_in = sasb_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         sasb_pkg::ST_PIX_ADDR: begin
            cmd.calc_addr = 1'b1;
            state_in      = sasb_pkg::ST_PIX_FETCH;
         end
         sasb_pkg::ST_PIX_FETCH: begin
            cmd.mem_read = 1'b1;
            state_in     = sasb_pkg::ST_PIX_WRITE;
         end
         sasb_pkg::ST_PIX_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = sasb_pkg::ST_IDLE;
         end
         sasb_pkg::ST_RD_ADDR: begin
            cmd.calc_addr = 1'b1;
            state_in      = sasb_pkg::ST_RD_FETCH;
         end
         sasb_pkg::ST_RD_FETCH: begin
            cmd.mem_read = 1'b1;
            state_in     = sasb_pkg::ST_RD_RESP;
         end
         sasb_pkg::ST_RD_RESP: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = sasb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sasb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/sasb_dp.sv */
// datapath of the sprite blitter: sprite walker, address unit, frame memory, result register
// depends on sasb_pkg; steered by sasb_ctrl

module sasb_dp #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sasb_pkg::cmd_type    cmd,
   output sasb_pkg::status_type status,
   input  logic [1:0]           req_mode,
   input  logic signed [9:0]    req_pos_x,
   input  logic signed [9:0]    req_pos_y,
   input  logic [7:0]           req_sprite_size,
   input  logic [7:0]           req_pixel_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_read_value
);

   localparam int CW    = sasb_pkg::COORD_W;
   localparam int COL_W = $clog2(FRAME_WIDTH);
   localparam int ROW_W = $clog2(FRAME_HEIGHT);
   localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0]   LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0]   ROW_PITCH = AW'(FRAME_WIDTH);
   localparam logic [CW-2:0]   COL_LIM   = (CW-1)'(FRAME_WIDTH);
   localparam logic [CW-2:0]   ROW_LIM   = (CW-1)'(FRAME_HEIGHT);

   // sprite walker
   logic signed [9:0] origin_x_ff;
   logic signed [9:0] origin_y_ff;
   logic [7:0]        size_ff;
   logic [7:0]        col_cnt_ff;
   logic [7:0]        row_cnt_ff;
   logic [7:0]        col_cnt_in;
   logic [7:0]        row_cnt_in;
   logic [7:0]        size_in;

   // latched item
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              hit_ff;
   logic [7:0]        pix_ff;
   logic [AW-1:0]     addr_ff;

   // clearing pass
   logic [AW-1:0]     clr_addr_ff;

   // memory
   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [7:0]        wr_val;
   logic [8:0]        sum;

   // result register
   logic              rsp_valid_ff;
   logic [7:0]        rsp_value_ff;

   logic signed [CW-1:0] sel_col;
   logic signed [CW-1:0] sel_row;
   logic                 hit;

   // frame position of the next sprite pixel, or the read position
   always_comb begin
      if (sasb_pkg::mode_type'(req_mode) == sasb_pkg::MODE_READ) begin
         sel_col = {req_pos_x[9], req_pos_x};
         sel_row = {req_pos_y[9], req_pos_y};
      end else begin
         sel_col = {origin_x_ff[9], origin_x_ff} + $signed({3'b000, col_cnt_ff});
         sel_row = {origin_y_ff[9], origin_y_ff} + $signed({3'b000, row_cnt_ff});
      end
      hit = !sel_col[CW-1] && (sel_col[CW-2:0] < COL_LIM) &&
            !sel_row[CW-1] && (sel_row[CW-2:0] < ROW_LIM);
   end

   // raster advance inside the sprite
   always_comb begin
      col_cnt_in = col_cnt_ff + 8'd1;
      row_cnt_in = row_cnt_ff;
      size_in    = size_ff;
      if (col_cnt_in >= size_ff) begin
         col_cnt_in = '0;
         row_cnt_in = row_cnt_ff + 8'd1;
         if (row_cnt_in >= size_ff) begin
            row_cnt_in = '0;
            size_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         size_ff     <= '0;
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
      end else if (cmd.start_sprite) begin
         origin_x_ff <= req_pos_x;
         origin_y_ff <= req_pos_y;
         size_ff     <= req_sprite_size;
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
      end else if (cmd.advance) begin
         size_ff    <= size_in;
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.latch) begin
         hit_ff <= hit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         col_ff <= sel_col[COL_W-1:0];
         row_ff <= sel_row[ROW_W-1:0];
         pix_ff <= req_pixel_value;
      end
      if (cmd.calc_addr) begin
         addr_ff <= AW'(row_ff) * ROW_PITCH + AW'(col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_start) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step && (clr_addr_ff != LAST_ADDR)) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // write port: zero for the clearing pass, else saturating add onto the fetched byte
   always_comb begin
      sum = {1'b0, rd_data_ff} + {1'b0, pix_ff};
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_val  = '0;
      end else begin
         wr_en   = cmd.mem_write;
         wr_addr = addr_ff;
         wr_val  = sum[8] ? sasb_pkg::PIX_MAX : sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_val;
      end
      if (cmd.mem_read && hit_ff) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_value_ff <= hit_ff ? rd_data_ff : 8'd0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;

   always_comb begin
      status.sprite_active = (size_ff != 8'd0);
      status.hit           = hit;
      status.clear_last    = (clr_addr_ff == LAST_ADDR);
      status.rsp_free      = !rsp_valid_ff || !rsp_stall;
   end

   a_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> hit_ff)
      else $error("frame write for a pixel outside the frame");

   a_idle_sprite_counts: assert property (@(posedge clock) disable iff (reset)
      (size_ff == 8'd0) |-> (col_cnt_ff == 8'd0 && row_cnt_ff == 8'd0))
      else $error("sprite counters left nonzero with no sprite active");

   a_counts_in_sprite: assert property (@(posedge clock) disable iff (reset)
      (size_ff != 8'd0) |-> (col_cnt_ff < size_ff && row_cnt_ff < size_ff))
      else $error("sprite position beyond sprite size");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("read result not presented after load");

endmodule

/* hw/rtl/saturating_additive_sprite_blit_top.sv */
// top level of the saturating additive sprite blitter
// depends on sasb_pkg, sasb_ctrl and sasb_dp

// The block keeps a FRAME_WIDTH x FRAME_HEIGHT frame of 8-bit pixels in one on-chip
// memory with one write and one registered read port, and handles one request at a
// time. A clear request (and reset itself) starts a clearing pass that writes one
// pixel a cycle over all FRAME_WIDTH*FRAME_HEIGHT pixels (64000 at the defaults),
// during which req_stall stays high. A sprite pixel that lands in the frame goes
// through a read-modify-write of the single memory: accept, address multiply, fetch,
// saturating add and write back; a pixel that falls outside the frame, or arrives with
// no sprite active, is done when it is accepted. A read goes through accept, address
// multiply and fetch, then waits to load the result register while an earlier result
// is still held there and stalled; a read outside the frame returns zero.
// The result register lets the next request be accepted while a result waits.

module saturating_additive_sprite_blit_top #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 200
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_mode,
   input  logic signed [9:0] req_pos_x,
   input  logic signed [9:0] req_pos_y,
   input  logic [7:0]        req_sprite_size,
   input  logic [7:0]        req_pixel_value,
   // result channel, one transfer per read request
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_read_value
);

   // commands from the controller, status back from the datapath
   sasb_pkg::cmd_type    cmd;
   sasb_pkg::status_type status;

   // sequencer: clearing pass, request decode, read-modify-write steps
   sasb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // sprite walker, address unit, frame memory and result register
   sasb_dp #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_mode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_sprite_size (req_sprite_size),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value)
   );

endmodule
